// ===== sv/rtprh_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rtprh_pkg
// Types, codes and sizes shared by the RTP retransmit history unit.
// ---------------------------------------------------------------------------
package rtprh_pkg;

    localparam int unsigned CAPACITY = 1024;
    localparam int unsigned SLOT_W   = $clog2(CAPACITY);
    localparam int unsigned SPAN_W   = SLOT_W + 1;
    localparam int unsigned SEQ_HALF = 32768;

    localparam logic ACT_STORE   = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic [1:0] CFG_RTT        = 2'd0;
    localparam logic [1:0] CFG_MIN_HOLD   = 2'd1;
    localparam logic [1:0] CFG_HOLD_FACT  = 2'd2;
    localparam logic [1:0] CFG_CULL_FACT  = 2'd3;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_GRANTED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_TOO_SOON  = 3'd4;

    typedef struct packed {
        logic        action;
        logic [15:0] seq_num;
        logic [47:0] now_ms;
        logic [15:0] packet_handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_handle;
        logic [7:0]  resend_count;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [47:0] send_time;
        logic [7:0]  resends;
        logic [15:0] handle;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DUR, S_CULL_CHK, S_CULL_EV, S_POP, S_SKIP_RD, S_SKIP_EV,
        S_FIND, S_DUP_EV, S_FWD, S_BACK, S_FIN, S_REQ, S_REQ_EV
    } t_state;

    typedef enum logic [1:0] {
        RET_CULL, RET_FWD, RET_BACK
    } t_ret;

endpackage
`default_nettype wire

// ===== sv/rtprh_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rtprh_ram
// Simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rtprh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/rtp_retransmit_history_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rtp_retransmit_history_unit
// Window of sent RTP packets keyed by sequence number; stores and answers
// retransmission requests from one table RAM.
// ---------------------------------------------------------------------------
// Request: index, RAM read, evaluate, then the result is registered; a
//   sequence number outside the window skips the RAM read. Store: size the
//   retention, cull old front entries (a full window drops without the age
//   check), skip empty slots, and drop entries one by one on a long stretch.
// Throughput: one item at a time; the RAM read-modify-write sets the pace.
// Reset: after i_rst_n the table valid bits are cleared by a sweep of
//   all 1024 entries, one entry per cycle, with o_in_stall high; config writes
//   are taken during the sweep.
module rtp_retransmit_history_unit
    import rtprh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    // configuration
    logic [15:0] r_rtt, r_min_hold;
    logic [3:0]  r_hold_fact, r_cull_fact;

    // window control
    t_state              r_state, n_state;
    t_ret                r_ret, n_ret;
    logic [SLOT_W-1:0]   r_clr;
    logic [15:0]         r_head_seq, n_head_seq;
    logic [SLOT_W-1:0]   r_head_slot, n_head_slot;
    logic [SPAN_W-1:0]   r_span, n_span;
    logic                r_fwd, n_fwd;
    logic [2:0]          r_status, n_status;

    // current item and retention times
    t_in_item    r_item;
    logic [19:0] r_dur;
    logic [23:0] r_durc;

    // result register
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;

    // RAM
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    t_entry            ram_wdata, q;
    logic [ENTRY_W-1:0] ram_q;

    rtprh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );
    assign q = t_entry'(ram_q);

    // -------- window index of the item's sequence number --------
    logic [15:0]       diff;
    logic              ahead;
    logic [16:0]       idx;          // signed, -32768 .. 32768
    logic              idx_neg, idx_zero, idx_ge_cap, idx_in_span, back_over;
    logic [15:0]       back;
    logic              span_zero, span_full;
    logic [SLOT_W-1:0] slot_idx, slot_tail;
    logic              out_free;

    assign diff  = r_item.seq_num - r_head_seq;
    assign ahead = (diff < 16'(SEQ_HALF))
                || ((diff == 16'(SEQ_HALF)) && (r_item.seq_num > r_head_seq));
    assign span_zero = (r_span == '0);
    assign span_full = (r_span >= SPAN_W'(CAPACITY));
    always_comb begin
        if (span_zero || diff == '0) begin
            idx = '0;
        end else begin
            idx = {~ahead, diff};
        end
    end
    assign idx_neg     = idx[16];
    assign idx_zero    = (idx == '0);
    assign idx_ge_cap  = !idx_neg && (idx[15:0] >= 16'(CAPACITY));
    assign idx_in_span = !idx_neg && (idx[15:0] < 16'(r_span));
    assign back        = 16'(~idx[15:0]) + 16'd1;
    assign back_over   = (17'(r_span) + 17'(back)) > 17'(CAPACITY);
    assign slot_idx    = r_head_slot + idx[SLOT_W-1:0];
    assign slot_tail   = r_head_slot + SLOT_W'(r_span - SPAN_W'(1));
    assign out_free    = !r_ov || !i_out_stall;

    // -------- time compares --------
    logic cull_keep, cull_old, too_soon;
    logic [19:0] dur_mul;
    assign dur_mul   = 20'(r_hold_fact) * 20'(r_rtt);
    assign cull_keep = (49'(q.send_time) + 49'(r_dur)) > 49'(r_item.now_ms);
    assign cull_old  = (49'(q.send_time) + 49'(r_durc)) <= 49'(r_item.now_ms);
    assign too_soon  = (q.send_time != '0) && (q.resends != '0)
                    && (49'(r_item.now_ms) < 49'(q.send_time) + 49'(r_rtt));

    logic [7:0] new_resends;
    assign new_resends = ((q.send_time != '0) && (q.resends != 8'hFF))
                       ? q.resends + 8'd1 : q.resends;

    // -------- next state --------
    logic [3:0] ret_sel;
    t_state ret_state;
    always_comb begin
        case (r_ret)
            RET_CULL: ret_state = S_CULL_CHK;
            RET_FWD:  ret_state = S_FWD;
            RET_BACK: ret_state = S_BACK;
            default:  ret_state = S_CULL_CHK;
        endcase
    end
    assign ret_sel = r_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_clr == SLOT_W'(CAPACITY - 1)) n_state = S_IDLE;
            S_IDLE:     if (i_in_valid) begin
                n_state = (i_in_data.action == ACT_STORE) ? S_DUR : S_REQ;
            end
            S_DUR:      n_state = S_CULL_CHK;
            S_CULL_CHK: begin
                if (span_zero)      n_state = S_FIND;
                else if (span_full) n_state = S_POP;
                else                n_state = S_CULL_EV;
            end
            S_CULL_EV:  n_state = (!cull_keep && cull_old) ? S_POP : S_FIND;
            S_POP:      n_state = S_SKIP_RD;
            S_SKIP_RD:  n_state = span_zero ? ret_state : S_SKIP_EV;
            S_SKIP_EV:  n_state = q.valid ? ret_state : S_SKIP_RD;
            S_FIND:     n_state = idx_in_span ? S_DUP_EV : S_FWD;
            S_DUP_EV:   n_state = (q.valid && idx_zero) ? S_POP : S_FWD;
            S_FWD: begin
                if (!span_zero && idx_ge_cap) n_state = S_FWD;
                else if (r_fwd)               n_state = S_SKIP_RD;
                else                          n_state = S_BACK;
            end
            S_BACK: begin
                if (!span_zero && idx_neg && back_over) n_state = S_BACK;
                else                                    n_state = S_FIN;
            end
            S_FIN:      if (out_free) n_state = S_IDLE;
            S_REQ: begin
                if (idx_in_span)   n_state = S_REQ_EV;
                else if (out_free) n_state = S_IDLE;
            end
            S_REQ_EV:   if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // -------- datapath and RAM control --------
    always_comb begin
        n_ret       = r_ret;
        n_head_seq  = r_head_seq;
        n_head_slot = r_head_slot;
        n_span      = r_span;
        n_fwd       = r_fwd;
        n_status    = r_status;
        n_ov        = r_ov && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_head_slot;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_head_slot;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_IDLE: begin
                n_status = ST_STORED;
                n_fwd    = 1'b0;
            end
            S_CULL_CHK: begin
                n_ret  = RET_CULL;
                ram_re = !span_zero && !span_full;
            end
            S_POP: begin
                // drop the front entry
                ram_we      = 1'b1;
                n_head_slot = r_head_slot + SLOT_W'(1);
                n_head_seq  = r_head_seq + 16'd1;
                n_span      = r_span - SPAN_W'(1);
            end
            S_SKIP_RD: begin
                ram_re = !span_zero;
            end
            S_SKIP_EV: begin
                if (!q.valid) begin
                    n_head_slot = r_head_slot + SLOT_W'(1);
                    n_head_seq  = r_head_seq + 16'd1;
                    n_span      = r_span - SPAN_W'(1);
                end
            end
            S_FIND: begin
                ram_re    = idx_in_span;
                ram_raddr = slot_idx;
            end
            S_DUP_EV: begin
                n_ret = RET_FWD;
                if (q.valid) begin
                    n_status  = ST_REPLACED;
                    ram_we    = !idx_zero;
                    ram_waddr = slot_idx;
                end
            end
            S_FWD: begin
                if (!span_zero && idx_ge_cap) begin
                    ram_we      = 1'b1;
                    n_head_slot = r_head_slot + SLOT_W'(1);
                    n_head_seq  = r_head_seq + 16'd1;
                    n_span      = r_span - SPAN_W'(1);
                    n_fwd       = 1'b1;
                end else if (r_fwd) begin
                    n_fwd = 1'b0;
                    n_ret = RET_BACK;
                end
            end
            S_BACK: begin
                if (!span_zero && idx_neg) begin
                    if (back_over) begin
                        // trim the back of the window
                        ram_we    = 1'b1;
                        ram_waddr = slot_tail;
                        n_span    = r_span - SPAN_W'(1);
                    end else begin
                        n_head_slot = r_head_slot - back[SLOT_W-1:0];
                        n_head_seq  = r_item.seq_num;
                        n_span      = r_span + back[SPAN_W-1:0];
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    ram_we          = 1'b1;
                    ram_wdata.valid = 1'b1;
                    ram_wdata.send_time = r_item.now_ms;
                    ram_wdata.handle    = r_item.packet_handle;
                    if (span_zero) begin
                        ram_waddr  = r_head_slot;
                        n_head_seq = r_item.seq_num;
                        n_span     = SPAN_W'(1);
                    end else begin
                        ram_waddr = slot_idx;
                        if (idx[SPAN_W-1:0] >= r_span) begin
                            n_span = idx[SPAN_W-1:0] + SPAN_W'(1);
                        end
                    end
                    n_ov  = 1'b1;
                    n_out = '{status: r_status, out_handle: '0, resend_count: '0};
                end
            end
            S_REQ: begin
                ram_re    = idx_in_span;
                ram_raddr = slot_idx;
                if (!idx_in_span && out_free) begin
                    n_ov  = 1'b1;
                    n_out = '{status: ST_NOT_FOUND, out_handle: '0, resend_count: '0};
                end
            end
            S_REQ_EV: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    if (!q.valid) begin
                        n_out = '{status: ST_NOT_FOUND, out_handle: '0, resend_count: '0};
                    end else if (too_soon) begin
                        n_out = '{status: ST_TOO_SOON, out_handle: '0,
                                  resend_count: q.resends};
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_idx;
                        ram_wdata = '{valid: 1'b1, send_time: r_item.now_ms,
                                      resends: new_resends, handle: q.handle};
                        n_out = '{status: ST_GRANTED, out_handle: q.handle,
                                  resend_count: new_resends};
                    end
                end
            end
            default: begin
                n_ret = r_ret;
            end
        endcase
    end

    // -------- registers --------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= RET_CULL;
            r_clr       <= '0;
            r_head_seq  <= '0;
            r_head_slot <= '0;
            r_span      <= '0;
            r_fwd       <= 1'b0;
            r_status    <= ST_STORED;
            r_ov        <= 1'b0;
            r_rtt       <= 16'd0;
            r_min_hold  <= 16'd1000;
            r_hold_fact <= 4'd3;
            r_cull_fact <= 4'd3;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_clr       <= (r_state == S_CLEAR) ? r_clr + SLOT_W'(1) : r_clr;
            r_head_seq  <= n_head_seq;
            r_head_slot <= n_head_slot;
            r_span      <= n_span;
            r_fwd       <= n_fwd;
            r_status    <= n_status;
            r_ov        <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RTT:       r_rtt       <= i_cfg_data;
                    CFG_MIN_HOLD:  r_min_hold  <= i_cfg_data;
                    CFG_HOLD_FACT: r_hold_fact <= i_cfg_data[3:0];
                    CFG_CULL_FACT: r_cull_fact <= i_cfg_data[3:0];
                    default:       r_rtt       <= r_rtt;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_data;
            // retention = max(factor * rtt, min hold)
            r_dur  <= (dur_mul < 20'(r_min_hold)) ? 20'(r_min_hold) : dur_mul;
        end
        if (r_state == S_DUR) begin
            r_durc <= 24'(r_dur) * 24'(r_cull_fact);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || (ret_sel == '1);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
